### design/tgs_pkg.sv
// tgs_pkg: shared types and constants for the tile grid store
// operation codes, register indexes, field widths, controller state, command/status structs
// no dependencies
package tgs_pkg;

  // field widths of the transactions
  localparam int FUNC_W      = 3;
  localparam int COORD_W     = 8;
  localparam int TILE_W      = 9;
  localparam int SOLID_ID_W  = 8;
  localparam int DIM_W       = 7;
  localparam int CFG_INDEX_W = 4;

  // stored tile ids are capped at 8 bits; wider port values are truncated
  localparam int MAX_ID_W = 8;

  typedef enum logic [2:0] {
    OP_SET         = 3'd0,
    OP_GET         = 3'd1,
    OP_SOLID_QUERY = 3'd2,
    OP_FILL        = 3'd3,
    OP_CLEAR       = 3'd4,
    OP_SOLID_CLEAR = 3'd5,
    OP_SOLID_ADD   = 3'd6,
    OP_NOP         = 3'd7
  } op_t;

  localparam logic [CFG_INDEX_W-1:0] REG_MAP_WIDTH  = 4'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MAP_HEIGHT = 4'd1;

  localparam logic [DIM_W-1:0] DIM_RESET = 7'd64;

  localparam logic signed [TILE_W-1:0] TILE_EMPTY = -9'sd1;

  typedef enum logic [5:0] {
    S_INIT  = 6'b000001,
    S_IDLE  = 6'b000010,
    S_ADDR  = 6'b000100,
    S_MEM   = 6'b001000,
    S_SWEEP = 6'b010000,
    S_DONE  = 6'b100000
  } state_t;

  typedef struct packed {
    logic capture;      // latch the request payload
    logic calc;         // bounds check and address product
    logic access;       // single memory access / solid set update
    logic sweep_write;  // write one cell of a sweep
    logic sweep_empty;  // sweep writes empty instead of the fill value
    logic finish;       // load the output register
  } cmd_t;

  typedef struct packed {
    op_t  op;
    logic sweep_last;
    logic out_free;
  } status_t;

endpackage

### design/tgs_if.sv
// tgs_if: valid/ready channel interfaces of the tile grid store
// request, response and configuration write channels; depends on tgs_pkg
interface tgs_req_if;
  import tgs_pkg::*;
  logic                         valid;
  logic                         ready;
  logic        [FUNC_W-1:0]     func;
  logic signed [COORD_W-1:0]    col;
  logic signed [COORD_W-1:0]    row;
  logic signed [TILE_W-1:0]     tile_value;
  logic        [SOLID_ID_W-1:0] solid_id;
  modport source (output valid, func, col, row, tile_value, solid_id, input ready);
  modport sink (input valid, func, col, row, tile_value, solid_id, output ready);
  modport monitor (input valid, func, col, row, tile_value, solid_id, ready);
endinterface

interface tgs_rsp_if;
  import tgs_pkg::*;
  logic                     valid;
  logic                     ready;
  logic signed [TILE_W-1:0] read_value;
  logic                     solid;
  logic                     inside_res;
  modport source (output valid, read_value, solid, inside_res, input ready);
  modport sink (input valid, read_value, solid, inside_res, output ready);
endinterface

interface tgs_cfg_if;
  import tgs_pkg::*;
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [DIM_W-1:0]       data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

### design/tile_grid_store.sv
// tile_grid_store: top level of the tile id grid memory with solid set
// joins the controller tgs_ctrl and the datapath tgs_dp; depends on tgs_pkg and tgs_if
//
//   channel  dir  carries                                     handshake
//   req      in   func, col, row, tile_value, solid_id        valid/ready
//   rsp      out  read_value, solid, inside_res               valid/ready
//   cfg      in   index (0 map_width, 1 map_height), data     valid/ready, always ready
//
// set, get, solid query, solid clear, solid add: accept, address multiply, memory access,
//   then result into the output register once that register has room
// fill and clear: all MAX_COLUMNS*MAX_ROWS cells, one cell per cycle through the
//   single write port of the tile memory
// after reset a clearing pass over the MAX_COLUMNS*MAX_ROWS cells (4096 by default)
//   empties the tile memory; req stays low during it, cfg writes are taken
// a finished result waits in the output register while the next request is accepted;
//   a stalled rsp holds the block only when a second result is ready
module tile_grid_store #(
  parameter int MAX_COLUMNS  = 64,
  parameter int MAX_ROWS     = 64,
  parameter int TILE_ID_BITS = 8
) (
  input logic        clk,
  input logic        rst,
  tgs_req_if.sink    req,
  tgs_rsp_if.source  rsp,
  tgs_cfg_if.sink    cfg
);
  import tgs_pkg::*;

  cmd_t    cmd;
  status_t status;
  logic    req_ready;

  assign req.ready = req_ready;

  // sequencing: one operation in flight
  tgs_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req_ready),
    .status    (status),
    .cmd       (cmd)
  );

  // storage, addressing and the output register
  tgs_dp #(
    .MAX_COLUMNS  (MAX_COLUMNS),
    .MAX_ROWS     (MAX_ROWS),
    .TILE_ID_BITS (TILE_ID_BITS)
  ) u_dp (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .rsp    (rsp),
    .cfg    (cfg),
    .cmd    (cmd),
    .status (status)
  );

  // a request transaction starts a multi-cycle operation
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> !req.ready)
    else $error("request accepted while an operation is in flight");

  // a result is only loaded when the output register has room
  a_finish_has_room: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> status.out_free)
    else $error("result would overwrite a pending response");

  // a loaded result shows up on the response channel
  a_finish_shows: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |=> rsp.valid)
    else $error("loaded result not presented");

  // sweeps never overlap request acceptance
  a_sweep_blocks_req: assert property (@(posedge clk) disable iff (rst)
    cmd.sweep_write |-> !req.ready)
    else $error("request accepted during a sweep");

endmodule

### design/tgs_ctrl.sv
// tgs_ctrl: sequencing state machine of the tile grid store
// drives datapath commands from the latched operation; depends on tgs_pkg
module tgs_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              req_valid,
  output logic              req_ready,
  input  tgs_pkg::status_t  status,
  output tgs_pkg::cmd_t     cmd
);
  import tgs_pkg::*;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_INIT;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    case (state)
      S_INIT: begin
        cmd.sweep_write = 1'b1;
        cmd.sweep_empty = 1'b1;
        if (status.sweep_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = S_ADDR;
        end
      end
      S_ADDR: begin
        cmd.calc = 1'b1;
        if (status.op inside {OP_FILL, OP_CLEAR}) begin
          state_next = S_SWEEP;
        end else begin
          state_next = S_MEM;
        end
      end
      S_MEM: begin
        cmd.access = 1'b1;
        state_next = S_DONE;
      end
      S_SWEEP: begin
        cmd.sweep_write = 1'b1;
        cmd.sweep_empty = (status.op != OP_FILL);
        if (status.sweep_last) state_next = S_DONE;
      end
      S_DONE: begin
        if (status.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_INIT;
      end
    endcase
  end

endmodule

### design/tgs_dp.sv
// tgs_dp: datapath of the tile grid store
// map size registers, address unit, tile memory, solid flags, output register; depends on tgs_pkg
module tgs_dp #(
  parameter int MAX_COLUMNS  = 64,
  parameter int MAX_ROWS     = 64,
  parameter int TILE_ID_BITS = 8
) (
  input  logic             clk,
  input  logic             rst,
  tgs_req_if.sink          req,
  tgs_rsp_if.source        rsp,
  tgs_cfg_if.sink          cfg,
  input  tgs_pkg::cmd_t    cmd,
  output tgs_pkg::status_t status
);
  import tgs_pkg::*;

  localparam int CELL_COUNT = MAX_COLUMNS * MAX_ROWS;
  localparam int ADDR_W     = (CELL_COUNT > 1) ? $clog2(CELL_COUNT) : 1;
  localparam int ID_W       = (TILE_ID_BITS < MAX_ID_W) ? TILE_ID_BITS : MAX_ID_W;
  localparam int CELL_W     = ID_W + 1;
  localparam int ID_COUNT   = 1 << ID_W;
  localparam int SUM_W      = 2 * DIM_W + 1;

  localparam logic [ADDR_W-1:0] LAST_ADDR   = ADDR_W'(CELL_COUNT - 1);
  localparam logic [8:0]        COL_LIMIT   = 9'(MAX_COLUMNS);
  localparam logic [8:0]        ROW_LIMIT   = 9'(MAX_ROWS);
  localparam logic [CELL_W-1:0] EMPTY_CELL  = {1'b1, {ID_W{1'b0}}};

  // configuration
  logic [DIM_W-1:0] map_width;
  logic [DIM_W-1:0] map_height;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      map_width  <= DIM_RESET;
      map_height <= DIM_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        REG_MAP_WIDTH:  map_width  <= cfg.data;
        REG_MAP_HEIGHT: map_height <= cfg.data;
        default: ;
      endcase
    end
  end

  // latched request
  op_t                         op_q;
  logic signed [COORD_W-1:0]   col_q;
  logic signed [COORD_W-1:0]   row_q;
  logic signed [TILE_W-1:0]    tval_q;
  logic        [SOLID_ID_W-1:0] sid_q;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op_q   <= op_t'(req.func);
      col_q  <= req.col;
      row_q  <= req.row;
      tval_q <= req.tile_value;
      sid_q  <= req.solid_id;
    end
  end

  // bounds check and row-major address
  logic [DIM_W-1:0]   width_eff;
  logic [DIM_W-1:0]   height_eff;
  logic               inside_calc;
  logic [2*DIM_W-1:0] row_offset;
  logic [SUM_W-1:0]   addr_sum;
  logic [ADDR_W-1:0]  addr_q;
  logic               inside_q;

  assign width_eff  = ({2'b00, map_width} > COL_LIMIT) ? COL_LIMIT[DIM_W-1:0] : map_width;
  assign height_eff = ({2'b00, map_height} > ROW_LIMIT) ? ROW_LIMIT[DIM_W-1:0] : map_height;

  assign inside_calc = !col_q[COORD_W-1] && !row_q[COORD_W-1] &&
                       (col_q[DIM_W-1:0] < width_eff) && (row_q[DIM_W-1:0] < height_eff);
  assign row_offset  = row_q[DIM_W-1:0] * width_eff;
  assign addr_sum    = {1'b0, row_offset} + SUM_W'(col_q[DIM_W-1:0]);

  always_ff @(posedge clk) begin
    if (cmd.calc) begin
      addr_q   <= ADDR_W'(addr_sum);
      inside_q <= inside_calc;
    end
  end

  // tile memory and sweep
  logic [CELL_W-1:0] tile_mem [CELL_COUNT];
  logic [CELL_W-1:0] enc_cell;
  logic [CELL_W-1:0] sweep_cell;
  logic [ADDR_W-1:0] sweep_addr;
  logic              mem_we;
  logic [ADDR_W-1:0] mem_addr;
  logic [CELL_W-1:0] mem_wdata;
  logic [CELL_W-1:0] rd_cell;

  assign enc_cell   = tval_q[TILE_W-1] ? EMPTY_CELL : {1'b0, tval_q[ID_W-1:0]};
  assign sweep_cell = cmd.sweep_empty ? EMPTY_CELL : enc_cell;

  assign mem_we    = cmd.sweep_write || (cmd.access && (op_q == OP_SET) && inside_q);
  assign mem_addr  = cmd.sweep_write ? sweep_addr : addr_q;
  assign mem_wdata = cmd.sweep_write ? sweep_cell : enc_cell;

  always_ff @(posedge clk) begin
    if (mem_we) tile_mem[mem_addr] <= mem_wdata;
    if (cmd.access) rd_cell <= tile_mem[addr_q];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_addr <= '0;
    end else if (cmd.sweep_write) begin
      sweep_addr <= (sweep_addr == LAST_ADDR) ? '0 : sweep_addr + 1'b1;
    end
  end

  // solid set, one flag per tile id
  logic [ID_COUNT-1:0] solid_flags;

  always_ff @(posedge clk) begin
    if (rst) begin
      solid_flags <= '0;
    end else if (cmd.access) begin
      case (op_q)
        OP_SOLID_CLEAR: solid_flags <= '0;
        OP_SOLID_ADD:   solid_flags[sid_q[ID_W-1:0]] <= 1'b1;
        default: ;
      endcase
    end
  end

  // result and output register
  logic                     lookup_hit;
  logic                     out_valid;
  logic signed [TILE_W-1:0] read_value_q;
  logic                     solid_q;
  logic                     inside_res_q;

  assign lookup_hit = (op_q inside {OP_GET, OP_SOLID_QUERY}) && inside_q && !rd_cell[ID_W];

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      read_value_q <= lookup_hit ? TILE_W'(rd_cell[ID_W-1:0]) : TILE_EMPTY;
      solid_q      <= lookup_hit && solid_flags[rd_cell[ID_W-1:0]];
      inside_res_q <= (op_q inside {OP_SET, OP_GET, OP_SOLID_QUERY}) && inside_q;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.read_value = read_value_q;
  assign rsp.solid      = solid_q;
  assign rsp.inside_res = inside_res_q;

  assign status.op         = op_q;
  assign status.sweep_last = (sweep_addr == LAST_ADDR);
  assign status.out_free   = !out_valid || rsp.ready;

endmodule
